@@ rtl/circular_deque_assert.svh @@
// Assertion macros used by the checker file.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cdq_pkg.sv @@
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH  = 128;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 8;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_REAR  = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_PUSH_FRONT = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_OUT  = 2'd2
  } back_state_e;

  // Decoded operation handed from front to back.
  typedef struct packed {
    logic              push;
    logic              at_front;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

@@ rtl/cdq_front.sv @@
`timescale 1ns / 1ps

module cdq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cdq_pkg::MODE_W-1:0]    mode_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] value_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_take_i,
  output cdq_pkg::cmd_t                 cmd_o
);
  import cdq_pkg::*;

  cmd_t       dec;
  cmd_t       fifo_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  always_comb begin
    dec.value = value_i;
    unique case (mode_e'(mode_i))
      MODE_PUSH_REAR:  begin dec.push = 1'b1; dec.at_front = 1'b0; end
      MODE_POP_FRONT:  begin dec.push = 1'b0; dec.at_front = 1'b1; end
      MODE_PUSH_FRONT: begin dec.push = 1'b1; dec.at_front = 1'b1; end
      MODE_POP_REAR:   begin dec.push = 1'b0; dec.at_front = 1'b0; end
      default:         begin dec.push = 1'b0; dec.at_front = 1'b0; end
    endcase
  end

  assign in_stall_o  = cnt_q[1];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  assign wr_en       = in_valid_i && !in_stall_o;
  assign rd_en       = cmd_valid_o && cmd_take_i;

  always_comb begin
    wptr_d = wr_en ? ~wptr_q : wptr_q;
    rptr_d = rd_en ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wptr_q] <= dec;
    end
  end

endmodule

@@ rtl/cdq_back.sv @@
`timescale 1ns / 1ps

module cdq_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_take_o,
  input  cdq_pkg::cmd_t                     cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cdq_pkg::DATA_W-1:0] data_o,
  output logic [cdq_pkg::STAT_W-1:0]        status_o,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy_o
);
  import cdq_pkg::*;

  back_state_e       state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] mem [DEPTH];
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  logic              full, empty;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    status_d   = status_q;
    data_d     = data_q;
    cmd_take_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = tail_q + PTR_W'(1);
    mem_raddr  = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          state_d    = ST_OUT;
          status_d   = STAT_DONE;
          if (cmd_i.push) begin
            data_d = '0;
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (cmd_i.at_front) begin
                head_d    = head_q - PTR_W'(1);
                mem_waddr = head_q - PTR_W'(1);
              end else begin
                tail_d    = tail_q + PTR_W'(1);
                mem_waddr = tail_q + PTR_W'(1);
              end
            end
          end else begin
            if (empty) begin
              status_d = STAT_EMPTY;
              data_d   = '1;
            end else begin
              mem_re  = 1'b1;
              count_d = count_q - CNT_W'(1);
              state_d = ST_READ;
              if (cmd_i.at_front) begin
                head_d    = head_q + PTR_W'(1);
                mem_raddr = head_q;
              end else begin
                tail_d    = tail_q - PTR_W'(1);
                mem_raddr = tail_q;
              end
            end
          end
        end
      end
      ST_READ: begin
        data_d  = rd_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= PTR_W'(DEPTH - 1);
      count_q  <= '0;
      status_q <= STAT_DONE;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_i.value;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign occupancy_o = OCC_W'(count_q);

endmodule

@@ rtl/circular_deque.sv @@
// A push result passes the command queue, then the back-end state ST_OUT; a
// pop also passes ST_READ, the registered read of the store, before ST_OUT.
// The back-end sequencer takes one command at a time, only from ST_IDLE.
// A 2-deep command queue takes input beats while a result waits, until full.
// Reset (async, active low): deque empty, front index 0, rear index DEPTH-1;
// store contents stay undefined until written.
`timescale 1ns / 1ps

module circular_deque (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cdq_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cdq_pkg::DATA_W-1:0] data_o,
  output logic [cdq_pkg::STAT_W-1:0]        status_o,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy_o
);
  import cdq_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  cdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  cdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

@@ rtl/circular_deque_chk.sv @@
`timescale 1ns / 1ps
`include "circular_deque_assert.svh"

module circular_deque_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [cdq_pkg::DATA_W-1:0] data_o,
  input logic [cdq_pkg::STAT_W-1:0]        status_o,
  input logic [cdq_pkg::OCC_W-1:0]         occupancy_o
);
  import cdq_pkg::*;

  `CDQ_ASSERT_NOW(a_full_result, out_valid_o && (status_o == STAT_FULL),
    (data_o == '0) && (occupancy_o == OCC_W'(DEPTH)), "full refusal inconsistent")
  `CDQ_ASSERT_NOW(a_empty_result, out_valid_o && (status_o == STAT_EMPTY),
    (data_o == '1) && (occupancy_o == '0), "empty refusal inconsistent")
  `CDQ_ASSERT_NOW(a_status_code, out_valid_o,
    (status_o == STAT_DONE) || (status_o == STAT_FULL) || (status_o == STAT_EMPTY),
    "undefined status code")
  `CDQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(data_o) && $stable(status_o) && $stable(occupancy_o),
    "stalled result beat changed")

endmodule

bind circular_deque circular_deque_chk u_chk (.*);
